@@ design/lpks_pkg.sv @@
package lpks_pkg;

    // Table geometry
    localparam int MAX_SLOTS = 4096;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = 13;
    localparam int KEY_W     = 64;
    localparam int STEP_W    = $clog2(KEY_W);

    localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(MAX_SLOTS);

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
    } t_lpks_in;

    typedef struct packed {
        logic [KEY_W-1:0] found_key;
        logic             hit;
        logic             table_full;
        logic [CNT_W-1:0] probe_count;
    } t_lpks_out;

    // Request and response of the remainder unit
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_lpks_mod_req;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] rem;
    } t_lpks_mod_rsp;

endpackage

@@ design/lpks_ram.sv @@
module lpks_ram #(
    parameter int P_WIDTH = 64,
    parameter int P_DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/lpks_mod.sv @@
module lpks_mod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpks_pkg::t_lpks_mod_req i_req,
    output lpks_pkg::t_lpks_mod_rsp o_rsp
);
    import lpks_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [KEY_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_divisor;
    logic [ADDR_W-1:0] r_rem;

    logic [ADDR_W:0]   n_trial;
    logic [ADDR_W-1:0] n_rem;

    // Shift in one dividend bit and subtract the divisor when it fits
    always_comb begin
        n_trial = {r_rem, r_div[KEY_W-1]};
        if (CNT_W'(n_trial) >= r_divisor) begin
            n_rem = ADDR_W'(CNT_W'(n_trial) - r_divisor);
        end else begin
            n_rem = n_trial[ADDR_W-1:0];
        end
    end

    // Run one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_div     <= i_req.dividend;
                r_divisor <= i_req.divisor;
                r_rem     <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_div <= {r_div[KEY_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(KEY_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

@@ design/linear_probe_key_set_core.sv @@
// Set of pre-hashed 64-bit keys in an open-addressing table, linear probing.
// Input channel: drive i_item (action, key) and raise start; the item is
// taken at a rising edge where start is high and busy is low. busy stays
// high until the item's result has been issued.
// Result channel: o_strobe is high for exactly one cycle with o_result
// valid in that cycle; the receiver cannot stall, so it must take it then.
// Configuration: i_cfg_we with i_cfg_data writes slots_in_use (0 acts as
// 1, above 4096 acts as 4096); write it only while busy is low.
// Sequence: the remainder unit reduces the key modulo the slot count, one
// bit per cycle, for the start slot; ST_MOD takes the remainder, ST_READ
// does the registered read of the start slot and ST_CHECK checks it and
// issues. Each slot stepped past adds a new address, then a registered
// read. busy drops together with the strobe, so the next item can be taken
// at the edge that ends the strobe cycle; no new item is taken while one
// is still in flight.
// Reset: synchronous, active low. After reset a clearing pass writes zero
// to all 4096 slots, one per cycle; busy is high throughout that pass.
module linear_probe_key_set_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lpks_pkg::t_lpks_in  i_item,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_data,
    output logic                o_strobe,
    output lpks_pkg::t_lpks_out o_result
);
    import lpks_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]  r_slots;
    logic [CNT_W-1:0]  r_n, n_n;
    logic              r_action, n_action;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [ADDR_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_steps, n_steps;
    logic              r_strobe, n_strobe;
    t_lpks_out         r_result, n_result;

    logic [CNT_W-1:0]  eff_slots;
    logic [CNT_W-1:0]  steps_inc;
    logic [CNT_W-1:0]  slot_inc;
    logic              key_match;
    logic              slot_empty;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;

    t_lpks_mod_req     mod_req;
    t_lpks_mod_rsp     mod_rsp;

    lpks_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    lpks_ram #(
        .P_WIDTH (KEY_W),
        .P_DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Clamp the configured slot count into 1 .. MAX_SLOTS
    always_comb begin
        if (r_slots == '0) begin
            eff_slots = CNT_W'(1);
        end else if (r_slots > SLOTS_MAX) begin
            eff_slots = SLOTS_MAX;
        end else begin
            eff_slots = r_slots;
        end
    end

    assign key_match  = (ram_rdata == r_key);
    assign slot_empty = (ram_rdata == '0);
    assign steps_inc  = r_steps + 1'b1;
    assign slot_inc   = {1'b0, r_slot} + 1'b1;

    // Sequence clear, remainder and probe walk
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_n       = r_n;
        n_action  = r_action;
        n_key     = r_key;
        n_slot    = r_slot;
        n_steps   = r_steps;
        n_strobe  = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = r_key;
        mod_req.start    = 1'b0;
        mod_req.dividend = r_key;
        mod_req.divisor  = r_n;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_W'(MAX_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_action = i_item.action;
                    n_key    = i_item.key;
                    n_n      = eff_slots;
                    n_steps  = '0;
                    mod_req.start    = 1'b1;
                    mod_req.dividend = i_item.key;
                    mod_req.divisor  = eff_slots;
                    n_state  = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_rsp.done) begin
                    n_slot  = mod_rsp.rem;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_action == ACT_LOOKUP && (key_match || slot_empty)) begin
                    // Lookup ends on the key or on an empty slot
                    n_result.found_key   = (key_match && r_key != '0) ? r_key : '0;
                    n_result.hit         = key_match && r_key != '0;
                    n_result.table_full  = 1'b0;
                    n_result.probe_count = r_steps;
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else if (r_action == ACT_INSERT && slot_empty) begin
                    // Insert stores a nonzero key in the first empty slot
                    ram_we = (r_key != '0);
                    n_result.found_key   = '0;
                    n_result.hit         = (r_key != '0);
                    n_result.table_full  = 1'b0;
                    n_result.probe_count = r_steps;
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else if (steps_inc == r_n) begin
                    // Full pass without a stop
                    n_result.found_key   = '0;
                    n_result.hit         = 1'b0;
                    n_result.table_full  = 1'b1;
                    n_result.probe_count = steps_inc;
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    // Advance to the next slot, wrapping to slot zero
                    n_steps = steps_inc;
                    n_slot  = (slot_inc >= r_n) ? '0 : slot_inc[ADDR_W-1:0];
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, working registers and the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_slots  <= SLOTS_MAX;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_slots <= i_cfg_data;
            end
        end
        r_n      <= n_n;
        r_action <= n_action;
        r_key    <= n_key;
        r_slot   <= n_slot;
        r_steps  <= n_steps;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ design/lpks_chk.sv @@
module lpks_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input lpks_pkg::t_lpks_out o_result
);
    import lpks_pkg::*;

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result only ends a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result issued while idle");

    // A full table never reports a hit
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.hit && o_result.table_full))
        else $error("hit and table_full together");

    // A returned key is a hit
    a_found_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.found_key != '0) |-> o_result.hit)
        else $error("found_key without hit");

    // Probe count stays within one pass
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.probe_count <= SLOTS_MAX))
        else $error("probe_count beyond one pass");

endmodule

bind linear_probe_key_set_core lpks_chk u_lpks_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import lpks_pkg::*;

    // Key-set predictor plus the queue of results still owed by the block
    class key_set_scoreboard;
        logic [KEY_W-1:0] slot_keys [MAX_SLOTS];
        logic [CNT_W-1:0] slot_count;
        t_lpks_out        owed_results [$];
        int               mismatches;
        int               checked;

        function new();
            foreach (slot_keys[i]) slot_keys[i] = '0;
            slot_count  = SLOTS_MAX;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void set_slot_count(logic [CNT_W-1:0] value);
            slot_count = value;
        endfunction

        // Zero acts as one slot, anything above the table size as the full table
        function int unsigned span();
            if (slot_count == '0) begin
                return 1;
            end
            if (slot_count > SLOTS_MAX) begin
                return MAX_SLOTS;
            end
            return int'(slot_count);
        endfunction

        function int waiting();
            return owed_results.size();
        endfunction

        // Walk the table for one accepted item and queue the result it must give
        function void note_item(t_lpks_in it);
            int unsigned      slots;
            int unsigned      slot;
            int unsigned      steps;
            logic [KEY_W-1:0] held;
            bit               done;
            t_lpks_out        want;
            slots = span();
            slot  = int'(it.key % 64'(slots));
            steps = 0;
            done  = 1'b0;
            want  = '0;
            want.table_full = 1'b1;
            while (!done && steps < slots) begin
                held = slot_keys[slot];
                if (it.action == ACT_LOOKUP) begin
                    if (held == it.key || held == '0) begin
                        done = 1'b1;
                        want.table_full = 1'b0;
                        if (held == it.key && it.key != '0) begin
                            want.found_key = it.key;
                            want.hit       = 1'b1;
                        end
                    end
                end else if (held == '0) begin
                    done = 1'b1;
                    want.table_full = 1'b0;
                    if (it.key != '0) begin
                        slot_keys[slot] = it.key;
                        want.hit        = 1'b1;
                    end
                end
                // Step to the next slot, wrapping at the end of the slots in use
                if (!done) begin
                    steps++;
                    slot = (slot + 1 == slots) ? 0 : slot + 1;
                end
            end
            want.probe_count = CNT_W'(steps);
            owed_results.push_back(want);
        endfunction

        // Compare one result with the oldest owed one
        function void check_result(t_lpks_out got);
            t_lpks_out want;
            checked++;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: unexpected, found_key=%h hit=%b full=%b probes=%0d",
                             checked, got.found_key, got.hit, got.table_full, got.probe_count);
                end
                return;
            end
            want = owed_results.pop_front();
            if (got.found_key !== want.found_key || got.hit !== want.hit ||
                got.table_full !== want.table_full || got.probe_count !== want.probe_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected found_key=%h hit=%b full=%b probes=%0d",
                             checked, want.found_key, want.hit, want.table_full,
                             want.probe_count);
                    $display("result %0d: actual   found_key=%h hit=%b full=%b probes=%0d",
                             checked, got.found_key, got.hit, got.table_full, got.probe_count);
                end
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_lpks_in         item_in = '0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             strobe;
    t_lpks_out        result;

    key_set_scoreboard sb;
    logic [KEY_W-1:0]  known_keys [$];

    linear_probe_key_set_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item_in),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_strobe   (strobe),
        .o_result   (result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check results first, then note a newly accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (strobe) begin
                sb.check_result(result);
            end
            if (start && !busy) begin
                sb.note_item(item_in);
            end
        end
    end

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic action, input logic [KEY_W-1:0] key);
        @(negedge i_clk);
        start          = 1'b1;
        item_in.action = action;
        item_in.key    = key;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and idle the sender
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        if (cycles > 1) begin
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Drop start and wait until every owed result has come
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.waiting() != 0) @(negedge i_clk);
    endtask

    // Write the slot count while the block is idle
    task automatic write_slot_count(input logic [CNT_W-1:0] value);
        drain_results();
        while (busy) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        sb.set_slot_count(value);
    endtask

    // Random key whose start slot is the given one
    function automatic logic [KEY_W-1:0] key_for_slot(input int unsigned slot,
                                                      input int unsigned slots);
        logic [KEY_W-1:0] r;
        r = {$urandom, $urandom};
        return r - (r % 64'(slots)) + 64'(slot);
    endfunction

    // Mostly inserts and lookups of stored keys, some absent keys, zero and noise
    task automatic random_item(output logic action, output logic [KEY_W-1:0] key);
        int unsigned slots;
        int unsigned window;
        int unsigned pick;
        slots  = sb.span();
        window = (slots > 32) ? 32 : slots;
        pick   = $urandom_range(0, 99);
        action = ACT_INSERT;
        key    = key_for_slot($urandom_range(0, slots - 1), slots);
        if (pick < 35) begin
            // Crowd half of the inserts into the low slots to build long runs
            if ($urandom_range(0, 1) == 1) begin
                key = key_for_slot($urandom_range(0, window - 1), slots);
            end
            known_keys.push_back(key);
        end else if (pick < 65 && known_keys.size() != 0) begin
            action = ACT_LOOKUP;
            key    = known_keys[$urandom_range(0, known_keys.size() - 1)];
        end else if (pick < 80) begin
            action = ACT_LOOKUP;
        end else if (pick < 85) begin
            action = ($urandom_range(0, 1) == 1) ? ACT_LOOKUP : ACT_INSERT;
            key    = '0;
        end else if (pick < 90 && known_keys.size() != 0) begin
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        end else begin
            action = ($urandom_range(0, 1) == 1) ? ACT_LOOKUP : ACT_INSERT;
            key    = {$urandom, $urandom};
        end
    endtask

    initial begin
        logic             action;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        int               sent;
        int               burst;
        int               gap_kind;
        sb = new();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full table at its reset size: key zero, top key, wrap and collisions
        send_item(ACT_LOOKUP, 64'h0);
        send_item(ACT_INSERT, 64'h0);
        send_item(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_INSERT, 64'h8000_0000_0000_0FFF);
        send_item(ACT_LOOKUP, 64'h8000_0000_0000_0FFF);
        send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_LOOKUP, 64'h0000_0000_0000_1000);
        send_item(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_LOOKUP, 64'h0);
        send_item(ACT_INSERT, 64'h1);

        // Slot count zero acts as one slot, already taken
        write_slot_count(13'd0);
        send_item(ACT_LOOKUP, 64'h5);
        send_item(ACT_INSERT, 64'h7);
        send_item(ACT_LOOKUP, 64'h8000_0000_0000_0FFF);
        send_item(ACT_LOOKUP, 64'h0);

        // Oversized count acts as the full table; earlier entries still there
        write_slot_count(13'h1FFF);
        send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_LOOKUP, 64'h1);

        // Shrink below the stored entries: full passes, inserts dropped
        write_slot_count(13'd2);
        send_item(ACT_LOOKUP, 64'h1);
        send_item(ACT_INSERT, 64'h2);
        write_slot_count(13'd1);
        send_item(ACT_INSERT, 64'h3);
        write_slot_count(SLOTS_MAX);

        // Random phases over tiny, small, medium and wide slot counts
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: count = CNT_W'($urandom_range(1, 8));
                1: count = CNT_W'($urandom_range(9, 64));
                2: count = CNT_W'($urandom_range(65, 256));
                default: count = CNT_W'($urandom_range(257, 8191));
            endcase
            write_slot_count(count);
            sent = 0;
            while (sent < 86) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    random_item(action, key);
                    send_item(action, key);
                    sent++;
                end
                gap_kind = $urandom_range(0, 9);
                if (gap_kind >= 4 && gap_kind <= 7) begin
                    hold_off($urandom_range(1, 8));
                end else if (gap_kind == 8) begin
                    hold_off($urandom_range(20, 160));
                end else if (gap_kind == 9) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (200) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.waiting() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #300_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
